FILE: rtl/core/mjat_pkg.sv
// shared constants and types for the multi-turn joint angle tracker
// depends on: nothing
package mjat_pkg;

  // joint index and per-joint storage
  localparam int JOINT_W     = 2;
  localparam int JOINT_SLOTS = 1 << JOINT_W;
  localparam int NUM_JOINTS  = 4;
  localparam logic [JOINT_W:0] JOINT_LIMIT = (JOINT_W + 1)'(NUM_JOINTS);

  // field widths
  localparam int COUNT_W   = 12;
  localparam int ACC_W     = 32;
  localparam int ANGLE_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int MASK_W    = JOINT_SLOTS;
  localparam int FIELD_W   = 16;
  localparam int ENTRY_W   = COUNT_W + ACC_W;

  // counts per turn and one turn in q.8 degrees
  localparam int TURN_COUNTS = 4095;
  localparam int FULL_Q8     = 92160;

  // 92160 / 4095 reduces to 2048 / 91
  localparam int DEG_SHIFT = 11;
  localparam int DEG_DEN   = 91;
  localparam int DEG_HALF  = DEG_DEN / 2;

  // coarse quotient |acc| / 91 by reciprocal, then one correction
  localparam int QA_SHIFT    = 38;
  localparam int RECIP_QA_W  = 32;
  localparam logic [RECIP_QA_W-1:0] RECIP_QA =
    RECIP_QA_W'((64'd1 << QA_SHIFT) / DEG_DEN);
  localparam int QA_W  = 25;
  localparam int REM_W = 8;
  localparam int RA_W  = 7;

  // fine quotient (2048 * rem + 45) / 91, exact for the narrow range used
  localparam int T_W        = RA_W + DEG_SHIFT;
  localparam int Q2_SHIFT   = 26;
  localparam int RECIP_Q2_W = 20;
  localparam logic [RECIP_Q2_W-1:0] RECIP_Q2 =
    RECIP_Q2_W'(((64'd1 << Q2_SHIFT) + DEG_DEN - 1) / DEG_DEN);
  localparam int Q2_W = 11;

  // angle path widths
  localparam int DMAG_W     = QA_W + DEG_SHIFT;
  localparam int REV_W      = DMAG_W + 2;
  localparam int PROD_W     = REV_W - 1 + FIELD_W;
  localparam int SCALE_FRAC = 14;
  localparam int ROUND_HALF = 1 << (SCALE_FRAC - 1);
  localparam int RQ_W       = PROD_W + 1 - SCALE_FRAC;
  localparam int SCL_W      = RQ_W + 1;
  localparam int OFF_SHIFT  = 4;
  localparam int RES_W      = SCL_W + 1;

  // register reset values
  localparam logic [CFG_W-1:0]   SCALE_RESET  = 64'h4000_4000_4000_4000;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 12'd3867;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSE_MASK   = 2'd0,
    REG_SCALE_WORDS    = 2'd1,
    REG_OFFSET_WORDS   = 2'd2,
    REG_WRAP_THRESHOLD = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/core/multiturn_joint_angle_tracker_core.sv
// multi-turn joint angle tracker, top level and only module
// depends on: mjat_pkg (rtl/core/mjat_pkg.sv)

// Each input word names a joint and carries its 12-bit absolute encoder
// count (4095 counts per turn). Per joint the block keeps the last count and
// a signed 32-bit turn accumulator in a small synchronous state memory; a jump
// larger than wrap_threshold counts as a wrap and is corrected by 4095. The
// first word of a joint seeds its state from the count. The accumulator is
// turned into degrees with 8 fraction bits (rounded), mirrored to 360 minus
// angle when the joint's reverse bit is set, scaled by the joint's unsigned
// Q2.14 gear factor (rounded), shifted by the signed 1/16-degree offset and
// clipped to 32 bits; saturated flags a clipped accumulator or angle. A joint
// index at or above NUM_JOINTS gives angle 0 with no flag and no state change.
// One word is in flight at a time: the state memory is read when the word is
// taken and updated and written back in S_UPD; the two reciprocal multiplies
// that divide by 91 and the gear multiply each have their own state. The result
// sits in an output register, so the next word is taken while a result waits
// for out_ready. Configuration is written through cfg_we/cfg_index/cfg_wdata,
// by the user only while idle; the block itself does not enforce this.
module multiturn_joint_angle_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mjat_pkg::JOINT_W-1:0]        in_joint,
  input  logic [mjat_pkg::COUNT_W-1:0]        in_raw_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mjat_pkg::JOINT_W-1:0]        out_joint_out,
  output logic signed [mjat_pkg::ANGLE_W-1:0] out_angle_q8,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  logic [mjat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mjat_pkg::CFG_W-1:0]          cfg_wdata
);
  import mjat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_MAG, S_QA, S_REM, S_Q2, S_DEG, S_RABS, S_MUL, S_RND, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [MASK_W-1:0]  reverse_mask_r;
  logic [CFG_W-1:0]   scale_words_r;
  logic [CFG_W-1:0]   offset_words_r;
  logic [COUNT_W-1:0] wrap_threshold_r;

  // per-joint state: seeded flags in flops, counts and accumulators in memory
  logic [JOINT_SLOTS-1:0] seeded_r;
  logic [ENTRY_W-1:0]     state_mem [JOINT_SLOTS];
  logic [ENTRY_W-1:0]     mem_rdata_r;
  logic                   mem_we;
  logic                   mem_re;
  logic [ENTRY_W-1:0]     mem_wdata;

  // word under work
  logic [JOINT_W-1:0]      joint_r;
  logic [COUNT_W-1:0]      raw_r;
  logic                    jbad_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    acc_sat_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        mag_r;
  logic [QA_W-1:0]         qa_r;
  logic [RA_W-1:0]         ra_r;
  logic [Q2_W-1:0]         q2_r;
  logic signed [REV_W-1:0] rev_r;
  logic                    rneg_r;
  logic [REV_W-2:0]        rmag_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [SCL_W-1:0] scl_r;

  // output register
  logic                      out_valid_r;
  logic [JOINT_W-1:0]        out_joint_r;
  logic signed [ANGLE_W-1:0] out_angle_q8_r;
  logic                      out_saturated_r;

  logic in_accept;
  logic in_joint_bad;
  logic out_free;

  // per-joint views of the packed scale and offset words
  logic [FIELD_W-1:0]        scale_arr [JOINT_SLOTS];
  logic signed [FIELD_W-1:0] off_arr   [JOINT_SLOTS];

  // accumulator update
  logic [COUNT_W-1:0]        last_cnt;
  logic signed [ACC_W-1:0]   acc_old;
  logic signed [COUNT_W:0]   delta;
  logic [COUNT_W-1:0]        step_mag;
  logic                      wrap;
  logic signed [COUNT_W+1:0] delta_x;
  logic signed [COUNT_W+1:0] turn_step;
  logic signed [COUNT_W+1:0] delta_adj;
  logic signed [ACC_W+1:0]   acc_sum;
  logic                      acc_fit;
  logic signed [ACC_W-1:0]   acc_upd;
  logic                      acc_sat_upd;

  // division by 91
  logic [ACC_W-1:0]                  mag_val;
  logic [ACC_W+RECIP_QA_W-1:0]       qa_prod;
  logic [REM_W-1:0]                  qa_lo_x;
  logic [REM_W-1:0]                  rem8;
  logic                              corr;
  logic [RA_W-1:0]                   ra_val;
  logic [T_W-1:0]                    t_val;
  logic [T_W+RECIP_Q2_W-1:0]         q2_prod;

  // angle path
  logic [DMAG_W-1:0]         dmag;
  logic                      rvs;
  logic signed [REV_W-1:0]   dterm;
  logic signed [REV_W-1:0]   rev_base;
  logic signed [REV_W-1:0]   rev_val;
  logic [REV_W-2:0]          rmag_val;
  logic [PROD_W-1:0]         prod_val;
  logic [RQ_W-1:0]           rq;
  logic signed [SCL_W-1:0]   scl_val;
  logic signed [RES_W-1:0]   res_val;
  logic                      res_fit;
  logic signed [ANGLE_W-1:0] angle_val;

  assign in_ready     = (state_r == S_IDLE);
  assign in_accept    = in_valid && in_ready;
  assign in_joint_bad = ({1'b0, in_joint} >= JOINT_LIMIT);
  assign out_free     = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_joint_out = out_joint_r;
  assign out_angle_q8  = out_angle_q8_r;
  assign out_saturated = out_saturated_r;

  always_comb begin
    for (int k = 0; k < JOINT_SLOTS; k++) begin
      scale_arr[k] = scale_words_r[k*FIELD_W +: FIELD_W];
      off_arr[k]   = offset_words_r[k*FIELD_W +: FIELD_W];
    end
  end

  // state memory: read when a word is taken, written back in the update cycle;
  // only one word is in flight so a read never overlaps a pending write
  assign mem_re    = in_accept;
  assign mem_we    = (state_r == S_UPD);
  assign mem_wdata = {raw_r, acc_upd};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[joint_r] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= state_mem[in_joint];
    end
  end

  // count step with wrap correction and saturating accumulate
  assign last_cnt  = mem_rdata_r[ENTRY_W-1:ACC_W];
  assign acc_old   = mem_rdata_r[ACC_W-1:0];
  assign delta     = $signed({1'b0, raw_r}) - $signed({1'b0, last_cnt});
  assign step_mag  = delta[COUNT_W] ? COUNT_W'(-delta) : delta[COUNT_W-1:0];
  assign wrap      = (step_mag > wrap_threshold_r);
  assign delta_x   = (COUNT_W + 2)'(delta);
  assign turn_step = (COUNT_W + 2)'(TURN_COUNTS);
  assign delta_adj = !wrap ? delta_x :
                     (delta[COUNT_W] ? delta_x + turn_step : delta_x - turn_step);
  assign acc_sum   = (ACC_W + 2)'(acc_old) + (ACC_W + 2)'(delta_adj);
  assign acc_fit   = (acc_sum[ACC_W+1:ACC_W-1] == '0) ||
                     (acc_sum[ACC_W+1:ACC_W-1] == '1);

  always_comb begin
    if (!seeded_r[joint_r]) begin
      acc_upd     = {{(ACC_W - COUNT_W){1'b0}}, raw_r};
      acc_sat_upd = 1'b0;
    end else if (acc_fit) begin
      acc_upd     = acc_sum[ACC_W-1:0];
      acc_sat_upd = 1'b0;
    end else begin
      acc_upd     = acc_sum[ACC_W+1] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
      acc_sat_upd = 1'b1;
    end
  end

  // |acc| * 2048 / 91 split as 2048 * (|acc| / 91) + (2048 * rem + 45) / 91
  assign mag_val = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign qa_prod = (ACC_W + RECIP_QA_W)'(mag_r) * (ACC_W + RECIP_QA_W)'(RECIP_QA);
  // remainder is below 182, so the low byte is exact
  assign qa_lo_x = REM_W'(qa_r[REM_W-1:0] * REM_W'(DEG_DEN));
  assign rem8    = mag_r[REM_W-1:0] - qa_lo_x;
  assign corr    = (rem8 >= REM_W'(DEG_DEN));
  assign ra_val  = corr ? RA_W'(rem8 - REM_W'(DEG_DEN)) : rem8[RA_W-1:0];
  assign t_val   = {ra_r, DEG_SHIFT'(DEG_HALF)};
  assign q2_prod = (T_W + RECIP_Q2_W)'(t_val) * (T_W + RECIP_Q2_W)'(RECIP_Q2);

  // fine quotient stays below 2048, so the magnitude is a plain concatenation
  assign dmag     = {qa_r, q2_r};
  assign rvs      = reverse_mask_r[joint_r];
  assign dterm    = (neg_r ^ rvs) ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
  assign rev_base = rvs ? REV_W'(FULL_Q8) : '0;
  assign rev_val  = rev_base + dterm;

  assign rmag_val = rev_r[REV_W-1] ? (REV_W - 1)'(-rev_r) : rev_r[REV_W-2:0];
  assign prod_val = PROD_W'(rmag_r) * PROD_W'(scale_arr[joint_r]);
  assign rq       = RQ_W'(((PROD_W + 1)'(prod_r) + (PROD_W + 1)'(ROUND_HALF)) >> SCALE_FRAC);
  assign scl_val  = rneg_r ? -$signed({1'b0, rq}) : $signed({1'b0, rq});

  // offset in 1/16 degree is q.4, so four bits up into q.8
  assign res_val  = RES_W'(scl_r) + (RES_W'(off_arr[joint_r]) <<< OFF_SHIFT);
  assign res_fit  = (res_val[RES_W-1:ANGLE_W-1] == '0) ||
                    (res_val[RES_W-1:ANGLE_W-1] == '1);
  assign angle_val = res_fit ? res_val[ANGLE_W-1:0] :
                     (res_val[RES_W-1] ? {1'b1, {(ANGLE_W - 1){1'b0}}}
                                       : {1'b0, {(ANGLE_W - 1){1'b1}}});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = in_joint_bad ? S_FIN : S_UPD;
        end
      end
      S_UPD:  state_nxt = S_MAG;
      S_MAG:  state_nxt = S_QA;
      S_QA:   state_nxt = S_REM;
      S_REM:  state_nxt = S_Q2;
      S_Q2:   state_nxt = S_DEG;
      S_DEG:  state_nxt = S_RABS;
      S_RABS: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_RND;
      S_RND:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      seeded_r         <= '0;
      reverse_mask_r   <= '0;
      scale_words_r    <= SCALE_RESET;
      offset_words_r   <= '0;
      wrap_threshold_r <= THRESH_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_REVERSE_MASK:   reverse_mask_r   <= cfg_wdata[MASK_W-1:0];
          REG_SCALE_WORDS:    scale_words_r    <= cfg_wdata;
          REG_OFFSET_WORDS:   offset_words_r   <= cfg_wdata;
          REG_WRAP_THRESHOLD: wrap_threshold_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      // in the final cycle the output register is reloaded below instead
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            joint_r <= in_joint;
            raw_r   <= in_raw_count;
            jbad_r  <= in_joint_bad;
          end
        end
        S_UPD: begin
          acc_r             <= acc_upd;
          acc_sat_r         <= acc_sat_upd;
          seeded_r[joint_r] <= 1'b1;
        end
        S_MAG: begin
          neg_r <= acc_r[ACC_W-1];
          mag_r <= mag_val;
        end
        S_QA: begin
          qa_r <= qa_prod[QA_SHIFT +: QA_W];
        end
        S_REM: begin
          qa_r <= qa_r + QA_W'(corr);
          ra_r <= ra_val;
        end
        S_Q2: begin
          q2_r <= q2_prod[Q2_SHIFT +: Q2_W];
        end
        S_DEG: begin
          rev_r <= rev_val;
        end
        S_RABS: begin
          rneg_r <= rev_r[REV_W-1];
          rmag_r <= rmag_val;
        end
        S_MUL: begin
          prod_r <= prod_val;
        end
        S_RND: begin
          scl_r <= scl_val;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_joint_r     <= joint_r;
            out_angle_q8_r  <= jbad_r ? '0 : angle_val;
            out_saturated_r <= !jbad_r && (acc_sat_r || !res_fit);
          end
        end
        default: ;
      endcase
    end
  end

  // a joint outside the configured set always reports a clean zero
  a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, out_joint_out} >= JOINT_LIMIT)
      |-> (out_angle_q8 == '0) && !out_saturated)
    else $error("out-of-range joint produced a nonzero result");

  // once a joint is seeded it stays seeded until reset
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((seeded_r & $past(seeded_r)) == $past(seeded_r)))
    else $error("seeded flag cleared without reset");

  // state memory is only written for an in-range joint
  a_mem_we_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !jbad_r && ({1'b0, joint_r} < JOINT_LIMIT))
    else $error("state memory written for an out-of-range joint");

  // only one word in flight: no word is taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ready)
    else $error("second word taken while one is in flight");

endmodule
